FILE: src/pn_pkg.sv
// Package for the path normaliser: sizes, character codes, segment kinds,
// controller states and output token kinds.
// No dependencies.
package pn_pkg;

  localparam int MAX_LEN     = 64;
  localparam int MAX_PARTS   = 32;
  localparam int STORE_DEPTH = 64;
  localparam int SEG_DEPTH   = 32;

  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int POS_W    = STORE_AW + 1;
  localparam int SEG_AW   = $clog2(SEG_DEPTH);
  localparam int KEPT_W   = SEG_AW + 1;
  localparam int CNT_W    = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_DOT,
    KIND_DOTDOT,
    KIND_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_POP,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    TOK_SLASH,
    TOK_DOT,
    TOK_MEM
  } tok_t;

endpackage

FILE: src/path_normalizer.sv
// Path normaliser: one character a beat in, normalised path out as a run. Depends on pn_pkg.
// Throughput: one character a cycle while loading; busy while a ".." pops a
// segment (segment-start memory read); one result a cycle on output, with busy
// held while the run is being produced.
// Reset (rst, synchronous) clears control state; the stores are not cleared.
module path_normalizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] char_in,
  input  logic       has_char,
  input  logic       last_in,
  output logic       busy,
  output logic       result_valid,
  output logic [7:0] char_out,
  output logic       last_out,
  output logic       overflow
);
  import pn_pkg::*;

  logic [7:0]          char_store [STORE_DEPTH];
  logic [POS_W-1:0]    segment_starts [SEG_DEPTH];
  logic [7:0]          store_rdata;
  logic [POS_W-1:0]    seg_rdata;

  state_t              state, state_next;
  logic [KEPT_W-1:0]   kept_count, kept_count_next;
  logic [POS_W-1:0]    write_pos, write_pos_next;
  logic [POS_W-1:0]    segment_start, segment_start_next;
  kind_t               segment_kind, segment_kind_next;
  logic                absolute_flag, absolute_flag_next;
  logic                first_flag, first_flag_next;
  logic                overflow_flag, overflow_flag_next;
  logic [POS_W-1:0]    emit_pos, emit_pos_next;
  logic [CNT_W-1:0]    in_count, in_count_next;
  logic                pend_last, pend_last_next;

  logic                tok_valid, tok_valid_next;
  tok_t                tok_kind, tok_kind_next;
  logic                tok_last, tok_last_next;
  logic                tok_ovf, tok_ovf_next;

  logic                cs_we, cs_re;
  logic [STORE_AW-1:0] cs_waddr, cs_raddr;
  logic [7:0]          cs_wdata;
  logic                ss_we, ss_re;
  logic [SEG_AW-1:0]   ss_waddr, ss_raddr;

  logic                accept, do_close, last_close, pop_req, finish, clear;
  logic [7:0]          ch;
  logic [POS_W-1:0]    slot;
  logic                room;

  assign accept = start && !busy;
  assign ch     = (char_in == CH_BSLASH) ? CH_SLASH : char_in;
  assign room   = (kept_count < KEPT_W'(SEG_DEPTH)) && (int'(kept_count) < MAX_PARTS);

  // datapath: load, close, pop and emit
  always_comb begin
    kept_count_next    = kept_count;
    write_pos_next     = write_pos;
    segment_start_next = segment_start;
    segment_kind_next  = segment_kind;
    absolute_flag_next = absolute_flag;
    first_flag_next    = first_flag;
    overflow_flag_next = overflow_flag;
    emit_pos_next      = emit_pos;
    in_count_next      = in_count;
    pend_last_next     = pend_last;
    tok_valid_next     = 1'b0;
    tok_kind_next      = tok_kind;
    tok_last_next      = tok_last;
    tok_ovf_next       = tok_ovf;
    cs_we    = 1'b0;
    cs_waddr = '0;
    cs_wdata = '0;
    cs_re    = 1'b0;
    cs_raddr = '0;
    ss_we    = 1'b0;
    ss_waddr = '0;
    ss_re    = 1'b0;
    ss_raddr = '0;
    do_close   = 1'b0;
    last_close = 1'b0;
    pop_req    = 1'b0;
    finish     = 1'b0;
    clear      = 1'b0;
    slot       = write_pos;

    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (has_char) begin
            if (in_count < CNT_W'(MAX_LEN)) begin
              in_count_next = in_count + CNT_W'(1);
              if (first_flag && ch == CH_SLASH) begin
                first_flag_next    = 1'b0;
                absolute_flag_next = 1'b1;
              end else begin
                first_flag_next = 1'b0;
                if (ch == CH_SLASH) begin
                  do_close = 1'b1;
                end else begin
                  case (segment_kind)
                    KIND_EMPTY: begin
                      segment_start_next = write_pos;
                      // separator already sits at write_pos when segments are kept
                      if (kept_count != '0 && write_pos < POS_W'(STORE_DEPTH))
                        slot = write_pos + POS_W'(1);
                      segment_kind_next = (ch == CH_DOT) ? KIND_DOT : KIND_OTHER;
                    end
                    KIND_DOT: segment_kind_next = (ch == CH_DOT) ? KIND_DOTDOT : KIND_OTHER;
                    default:  segment_kind_next = KIND_OTHER;
                  endcase
                  write_pos_next = slot;
                  if (slot < POS_W'(STORE_DEPTH)) begin
                    cs_we          = 1'b1;
                    cs_waddr       = slot[STORE_AW-1:0];
                    cs_wdata       = ch;
                    write_pos_next = slot + POS_W'(1);
                  end
                end
              end
            end else begin
              overflow_flag_next = 1'b1;
            end
          end
          if (last_in) begin
            if (first_flag_next) clear = 1'b1;
            else last_close = 1'b1;
          end
          if (do_close || last_close) begin
            case (segment_kind_next)
              KIND_DOT: write_pos_next = segment_start_next;
              KIND_DOTDOT: begin
                write_pos_next = segment_start_next;
                if (kept_count != '0) begin
                  pop_req         = 1'b1;
                  pend_last_next  = last_in;
                  kept_count_next = kept_count - KEPT_W'(1);
                  ss_re           = 1'b1;
                  ss_raddr        = kept_count_next[SEG_AW-1:0];
                end
              end
              KIND_OTHER: begin
                if (room) begin
                  ss_we           = 1'b1;
                  ss_waddr        = kept_count[SEG_AW-1:0];
                  kept_count_next = kept_count + KEPT_W'(1);
                  if (!last_in && write_pos_next < POS_W'(STORE_DEPTH)) begin
                    cs_we    = 1'b1;
                    cs_waddr = write_pos_next[STORE_AW-1:0];
                    cs_wdata = CH_SLASH;
                  end
                end else begin
                  write_pos_next = segment_start_next;
                end
              end
              default: ;
            endcase
            segment_kind_next = KIND_EMPTY;
          end
        end
      end
      S_POP: begin
        write_pos_next = seg_rdata;
      end
      S_EMIT: begin
        tok_valid_next = 1'b1;
        tok_ovf_next   = overflow_flag;
        if (absolute_flag) begin
          absolute_flag_next = 1'b0;
          tok_kind_next      = TOK_SLASH;
          tok_last_next      = (write_pos == '0);
        end else if (write_pos == '0) begin
          tok_kind_next = TOK_DOT;
          tok_last_next = 1'b1;
        end else begin
          tok_kind_next = TOK_MEM;
          cs_re         = 1'b1;
          cs_raddr      = emit_pos[STORE_AW-1:0];
          emit_pos_next = emit_pos + POS_W'(1);
          tok_last_next = (emit_pos_next == write_pos);
        end
        finish = tok_last_next;
      end
      default: ;
    endcase

    if (clear || finish) begin
      kept_count_next    = '0;
      write_pos_next     = '0;
      segment_start_next = '0;
      segment_kind_next  = KIND_EMPTY;
      absolute_flag_next = 1'b0;
      first_flag_next    = 1'b1;
      overflow_flag_next = 1'b0;
      emit_pos_next      = '0;
      in_count_next      = '0;
      pend_last_next     = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (pop_req) state_next = S_POP;
        else if (last_close) state_next = S_EMIT;
      end
      S_POP:  state_next = pend_last ? S_EMIT : S_LOAD;
      S_EMIT: if (finish) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    busy         = (state != S_LOAD);
    result_valid = tok_valid;
    last_out     = tok_last;
    overflow     = tok_ovf;
    case (tok_kind)
      TOK_SLASH: char_out = CH_SLASH;
      TOK_DOT:   char_out = CH_DOT;
      default:   char_out = store_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cs_we) char_store[cs_waddr] <= cs_wdata;
    if (cs_re) store_rdata <= char_store[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (ss_we) segment_starts[ss_waddr] <= segment_start_next;
    if (ss_re) seg_rdata <= segment_starts[ss_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      kept_count    <= '0;
      write_pos     <= '0;
      segment_start <= '0;
      segment_kind  <= KIND_EMPTY;
      absolute_flag <= 1'b0;
      first_flag    <= 1'b1;
      overflow_flag <= 1'b0;
      emit_pos      <= '0;
      in_count      <= '0;
      pend_last     <= 1'b0;
      tok_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      kept_count    <= kept_count_next;
      write_pos     <= write_pos_next;
      segment_start <= segment_start_next;
      segment_kind  <= segment_kind_next;
      absolute_flag <= absolute_flag_next;
      first_flag    <= first_flag_next;
      overflow_flag <= overflow_flag_next;
      emit_pos      <= emit_pos_next;
      in_count      <= in_count_next;
      pend_last     <= pend_last_next;
      tok_valid     <= tok_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_kind <= tok_kind_next;
    tok_last <= tok_last_next;
    tok_ovf  <= tok_ovf_next;
  end

endmodule
